// ===== src/multi_channel_timeout_table_macros.svh =====
// Assertion macros shared by the timeout table.
`ifndef MULTI_CHANNEL_TIMEOUT_TABLE_MACROS_SVH
`define MULTI_CHANNEL_TIMEOUT_TABLE_MACROS_SVH

// Checks that a condition holds on every clock edge outside reset.
`define MCTT_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: label");

// Checks that a trigger implies a consequence in the same cycle.
`define MCTT_ASSERT_IMPLIES(label, clk, rst, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("assertion failed: label");

`endif

// ===== src/mctt_pkg.sv =====
`timescale 1ns / 1ps

package mctt_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;
  localparam int MAX_RESULTS    = 16;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
  localparam int PERIOD_W       = 31;
  localparam int ID_W           = 4;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_ARMED       = 2'd1;
  localparam logic [1:0] STATUS_ZERO_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic add;
    logic remove;
    logic start;
    logic go;
  } cell_ctl_t;

endpackage

// ===== src/mctt_cell.sv =====
`timescale 1ns / 1ps

module mctt_cell #(
  parameter int TIME_BITS = mctt_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mctt_pkg::cell_ctl_t           ctl,
  input  logic                          sel,
  input  logic [TIME_BITS-1:0]          time_now,
  input  logic [mctt_pkg::PERIOD_W-1:0] period_ms,
  input  logic                          one_shot,
  input  logic                          tok_in,
  output logic                          tok,
  output logic                          armed,
  output logic                          fire
);
  import mctt_pkg::*;

  logic [TIME_BITS-1:0] base_time;
  logic [PERIOD_W-1:0]  period_len;
  logic                 fires_once;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] period_ext;
  logic                 due;

  assign period_ext = {{(TIME_BITS - PERIOD_W){1'b0}}, period_len};
  assign elapsed    = time_now - base_time;
  assign due        = armed && (elapsed >= period_ext);
  assign fire       = tok && due && ctl.go;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
      tok   <= 1'b0;
    end else begin
      if (ctl.start || ctl.go) begin
        tok <= tok_in;
      end
      if (ctl.add && sel) begin
        armed <= 1'b1;
      end else if (ctl.remove && sel) begin
        armed <= 1'b0;
      end else if (fire && fires_once) begin
        armed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add && sel) begin
      base_time  <= time_now;
      period_len <= period_ms;
      fires_once <= one_shot;
    end else if (fire && !fires_once) begin
      base_time <= base_time + period_ext;
    end
  end

endmodule

// ===== src/mctt_ctrl.sv =====
`timescale 1ns / 1ps

module mctt_ctrl #(
  parameter int NUM_TIMERS = mctt_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = mctt_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [mctt_pkg::PERIOD_W-1:0] period_ms,
  input  logic                          one_shot,
  input  logic                          in_range,
  input  logic                          armed_sel,
  input  logic                          any_fire,
  output logic [TIME_BITS-1:0]          time_now,
  output mctt_pkg::cell_ctl_t           ctl,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          fired,
  output logic [mctt_pkg::ID_W-1:0]     fired_id,
  output logic                          last_result
);
  import mctt_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  state_t               state, state_next;
  logic [TIME_BITS-1:0] time_now_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 pend_valid, pend_valid_next;
  logic [IDX_W-1:0]     pend_id, pend_id_next;
  logic                 out_valid_next;
  logic [1:0]           status_next;
  logic                 fired_next;
  logic [ID_W-1:0]      fired_id_next;
  logic                 last_result_next;
  logic                 out_free;
  logic                 accept;
  logic [1:0]           add_status;
  logic [IDX_W+ID_W-1:0] pend_ext;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;
  assign pend_ext = {{ID_W{1'b0}}, pend_id};

  always_comb begin
    if (period_ms == '0 && !one_shot) begin
      add_status = STATUS_ZERO_PERIOD;
    end else if (armed_sel) begin
      add_status = STATUS_ARMED;
    end else begin
      add_status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      time_now   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      time_now   <= time_now_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    cnt         <= cnt_next;
    pend_id     <= pend_id_next;
    status      <= status_next;
    fired       <= fired_next;
    fired_id    <= fired_id_next;
    last_result <= last_result_next;
  end

  always_comb begin
    state_next       = state;
    time_now_next    = time_now;
    idx_next         = idx;
    cnt_next         = cnt;
    pend_valid_next  = pend_valid;
    pend_id_next     = pend_id;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    fired_next       = fired;
    fired_id_next    = fired_id;
    last_result_next = last_result;
    ctl              = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_ADD: begin
              ctl.add          = in_range && (add_status == STATUS_OK);
              out_valid_next   = 1'b1;
              status_next      = in_range ? add_status : STATUS_OK;
              fired_next       = 1'b0;
              fired_id_next    = '0;
              last_result_next = 1'b1;
            end
            REQ_REMOVE: begin
              ctl.remove       = in_range;
              out_valid_next   = 1'b1;
              status_next      = STATUS_OK;
              fired_next       = 1'b0;
              fired_id_next    = '0;
              last_result_next = 1'b1;
            end
            REQ_TICK: begin
              ctl.start       = 1'b1;
              time_now_next   = time_now + 1'b1;
              idx_next        = '0;
              cnt_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = ST_SCAN;
            end
            default: begin
              out_valid_next   = 1'b1;
              status_next      = STATUS_OK;
              fired_next       = 1'b0;
              fired_id_next    = '0;
              last_result_next = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          ctl.go = 1'b1;
          if (any_fire) begin
            if (pend_valid) begin
              out_valid_next   = 1'b1;
              status_next      = STATUS_OK;
              fired_next       = 1'b1;
              fired_id_next    = pend_ext[ID_W-1:0];
              last_result_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = idx;
            cnt_next        = cnt + 1'b1;
          end
          if ((idx == IDX_W'(NUM_TIMERS - 1)) ||
              (any_fire && (cnt == CNT_W'(MAX_RESULTS - 1)))) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_valid_next   = 1'b1;
          status_next      = STATUS_OK;
          fired_next       = 1'b1;
          fired_id_next    = pend_ext[ID_W-1:0];
          last_result_next = 1'b1;
          pend_valid_next  = 1'b0;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/multi_channel_timeout_table.sv =====
`timescale 1ns / 1ps
// Table of NUM_TIMERS numbered timeout channels driven by a millisecond tick.
// An add transaction arms a channel with a period and a one-shot or periodic
// flag and answers with one status result in the cycle after it is taken; a
// remove transaction disarms a channel and answers the same way. A tick
// transaction advances time by one and walks a scan token along the row of
// channel cells, one cell per cycle while the output is not stalled, in
// ascending channel order. Each due channel is reported once as a fired
// result (one-shot channels disarm, periodic ones move their base forward
// by one period), and the last fired result of the tick carries last_result.
// After a tick is taken the input stalls through at most one scan step per
// channel and one flush step, plus any time the output is stalled, and a
// tick with nothing due gives no result at all. A tick reports at most 16
// channels; any further due channels stay due for the next tick. The block
// takes one transaction at a time: the input stalls while a scan is running.
// Channel numbers at or above NUM_TIMERS are ignored with an ok status.

`include "multi_channel_timeout_table_macros.svh"

module multi_channel_timeout_table #(
  parameter int NUM_TIMERS = mctt_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = mctt_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [mctt_pkg::ID_W-1:0]     timer_id,
  input  logic [mctt_pkg::PERIOD_W-1:0] period_ms,
  input  logic                          one_shot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          fired,
  output logic [mctt_pkg::ID_W-1:0]     fired_id,
  output logic                          last_result
);
  import mctt_pkg::*;

  cell_ctl_t            ctl;
  logic [TIME_BITS-1:0] time_now;
  logic [NUM_TIMERS-1:0] sel_vec;
  logic [NUM_TIMERS-1:0] armed_vec;
  logic [NUM_TIMERS-1:0] fire_vec;
  logic [NUM_TIMERS-1:0] tok_vec;
  logic [NUM_TIMERS-1:0] tok_chain;
  logic                 in_range;
  logic                 armed_sel;
  logic                 any_fire;

  // The channel decode doubles as the range check: no cell matches an id
  // at or above NUM_TIMERS.
  assign in_range  = |sel_vec;
  assign armed_sel = |(armed_vec & sel_vec);
  assign any_fire  = |fire_vec;

  // The scan token enters at channel zero when a tick starts and moves one
  // cell toward higher channel numbers every scan step. Starting a tick
  // also flushes any token left over from a scan that ended early.
  genvar gi;
  generate
    for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
      assign sel_vec[gi] = (int'(timer_id) == gi);
      if (gi == 0) begin : g_head
        assign tok_chain[gi] = ctl.start;
      end else begin : g_link
        assign tok_chain[gi] = tok_vec[gi-1] && !ctl.start;
      end

      mctt_cell #(
        .TIME_BITS(TIME_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl),
        .sel      (sel_vec[gi]),
        .time_now (time_now),
        .period_ms(period_ms),
        .one_shot (one_shot),
        .tok_in   (tok_chain[gi]),
        .tok      (tok_vec[gi]),
        .armed    (armed_vec[gi]),
        .fire     (fire_vec[gi])
      );
    end
  endgenerate

  mctt_ctrl #(
    .NUM_TIMERS(NUM_TIMERS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .period_ms  (period_ms),
    .one_shot   (one_shot),
    .in_range   (in_range),
    .armed_sel  (armed_sel),
    .any_fire   (any_fire),
    .time_now   (time_now),
    .ctl        (ctl),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .fired      (fired),
    .fired_id   (fired_id),
    .last_result(last_result)
  );

  // Only the cell holding the token may fire, so at most one fires a cycle.
  `MCTT_ASSERT_ALWAYS(a_one_fire, clk, rst, $onehot0(fire_vec))
  // The scan token never splits as it moves along the row.
  `MCTT_ASSERT_ALWAYS(a_one_token, clk, rst, $onehot0(tok_vec))
  // Results that report a channel always carry an ok status.
  `MCTT_ASSERT_IMPLIES(a_fired_ok, clk, rst, out_valid && fired, status == STATUS_OK)
  // A result that reports no channel is always the only one of its transaction.
  `MCTT_ASSERT_IMPLIES(a_plain_last, clk, rst, out_valid && !fired, last_result)

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mctt_pkg::*;

  // The block runs with its default sizes, so the testbench mirrors them here.
  localparam int NUM_CH = NUM_TIMERS_DEF;
  localparam int TIME_W = TIME_BITS_DEF;

  // The request type that the block leaves unused; it must still answer once.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // A tick walks all channels and then flushes, so the block can stay busy
  // this long after its last result before it is truly quiet.
  localparam int QUIET_CYCLES = 3 * NUM_CH + 20;

  // Hard stop for the whole run, far above the slowest legal run.
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  typedef struct packed {
    logic [1:0]      status;
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            last_result;
  } report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          req_type = REQ_ADD;
  logic [ID_W-1:0]     timer_id = '0;
  logic [PERIOD_W-1:0] period_ms = '0;
  logic                one_shot = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          status;
  logic                fired;
  logic [ID_W-1:0]     fired_id;
  logic                last_result;

  // Shadow copy of the channel table, updated as each request transaction is
  // accepted. It gives the results that the block must produce, in order.
  logic [TIME_W-1:0]   now_ms;
  logic [TIME_W-1:0]   ch_base [NUM_CH];
  logic [PERIOD_W-1:0] ch_period [NUM_CH];
  logic                ch_once [NUM_CH];
  logic                ch_armed [NUM_CH];

  report_t expected_reports[$];

  // Idle rates for the request side and the result side, in percent.
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  int mismatch_count = 0;
  int requests_sent = 0;
  int reports_seen = 0;
  int fires_seen = 0;
  int error_reports = 0;
  int busiest_tick = 0;

  multi_channel_timeout_table DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .timer_id    (timer_id),
    .period_ms   (period_ms),
    .one_shot    (one_shot),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .fired       (fired),
    .fired_id    (fired_id),
    .last_result (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted request to the shadow table and queue the results it
  // must cause. Add and remove always answer once; a tick answers once per
  // channel that comes due, and not at all when nothing is due.
  function automatic void table_apply(input logic [1:0] req, input logic [ID_W-1:0] id,
                                      input logic [PERIOD_W-1:0] per, input logic once);
    report_t rpt;
    logic [TIME_W-1:0] elapsed;
    int due_ids[$];
    rpt = '0;
    rpt.status = STATUS_OK;
    rpt.last_result = 1'b1;
    case (req)
      REQ_ADD: begin
        // A zero period on a periodic add is rejected before the armed check.
        if (per == '0 && !once) begin
          rpt.status = STATUS_ZERO_PERIOD;
        end else if (ch_armed[id]) begin
          rpt.status = STATUS_ARMED;
        end else begin
          ch_base[id] = now_ms;
          ch_period[id] = per;
          ch_once[id] = once;
          ch_armed[id] = 1'b1;
        end
        expected_reports.push_back(rpt);
      end
      REQ_REMOVE: begin
        ch_armed[id] = 1'b0;
        expected_reports.push_back(rpt);
      end
      REQ_TICK: begin
        now_ms = now_ms + 1'b1;
        // Elapsed time is taken modulo the counter width, so a wrapped counter
        // still compares correctly against the base.
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (ch_armed[ch] && due_ids.size() < MAX_RESULTS) begin
            elapsed = now_ms - ch_base[ch];
            if (elapsed >= TIME_W'(ch_period[ch])) begin
              if (ch_once[ch]) ch_armed[ch] = 1'b0;
              else ch_base[ch] = ch_base[ch] + TIME_W'(ch_period[ch]);
              due_ids.push_back(ch);
            end
          end
        end
        if (due_ids.size() > busiest_tick) busiest_tick = due_ids.size();
        foreach (due_ids[i]) begin
          rpt.fired = 1'b1;
          rpt.fired_id = due_ids[i][ID_W-1:0];
          rpt.last_result = (i == due_ids.size() - 1);
          expected_reports.push_back(rpt);
        end
      end
      default: begin
        expected_reports.push_back(rpt);
      end
    endcase
  endfunction

  // Send one request transaction and hold it until the block takes it. The
  // payload only changes once the previous transaction has been accepted,
  // and valid is only dropped when the sender decides to idle.
  task automatic send_request(input logic [1:0] req, input logic [ID_W-1:0] id,
                              input logic [PERIOD_W-1:0] per, input logic once);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_type  <= req;
    timer_id  <= id;
    period_ms <= per;
    one_shot  <= once;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Accepted at this edge; results can only show up from the next edge on.
    table_apply(req, id, per, once);
    requests_sent++;
  endtask

  // Stop sending until every expected result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  // Mostly short periods so that channels come due often; now and then a
  // huge or single-bit period so every bit of the field gets exercised.
  function automatic logic [PERIOD_W-1:0] pick_period();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return PERIOD_W'($urandom_range(0, 6));
    if (sel < 85) return PERIOD_W'($urandom_range(7, 40));
    if (sel < 95) return PERIOD_W'($urandom());
    if (sel < 97) return {PERIOD_W{1'b1}};
    return PERIOD_W'(1) << $urandom_range(0, PERIOD_W - 1);
  endfunction

  // Compare one accepted result transaction against the oldest expectation.
  task automatic check_report();
    report_t want;
    report_t got;
    got = '{status, fired, fired_id, last_result};
    reports_seen++;
    if (fired) fires_seen++;
    if (status != STATUS_OK) error_reports++;
    if (expected_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result status=%0d fired=%0b id=%0d last=%0b",
                 $realtime, got.status, got.fired, got.fired_id, got.last_result);
    end else begin
      want = expected_reports.pop_front();
      if (got != want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result mismatch: expected status=%0d fired=%0b id=%0d last=%0b",
                   $realtime, want.status, want.fired, want.fired_id, want.last_result);
          $display("%0t:                  got status=%0d fired=%0b id=%0d last=%0b",
                   $realtime, got.status, got.fired, got.fired_id, got.last_result);
        end
      end
    end
  endtask

  // Result side: sample the handshake with the values from before the edge,
  // then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_report();
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Adds, removes and their error cases, with a zero-period one-shot that
  // must fire on the very next tick.
  task automatic test_add_remove_errors();
    send_request(REQ_ADD, 4'd0, '0, 1'b1);
    send_request(REQ_ADD, 4'd0, 31'd5, 1'b1);
    send_request(REQ_ADD, 4'd1, '0, 1'b0);
    send_request(REQ_ADD, 4'd15, {PERIOD_W{1'b1}}, 1'b0);
    send_request(REQ_ADD, 4'd2, 31'd1, 1'b0);
    send_request(REQ_ADD, 4'd3, 31'd3, 1'b1);
    // Zero periodic on an armed channel reports the zero period, not armed.
    send_request(REQ_ADD, 4'd3, '0, 1'b0);
    send_request(REQ_TICK, 4'd0, '0, 1'b0);
    send_request(REQ_REMOVE, 4'd0, '0, 1'b0);
    send_request(REQ_UNUSED, 4'hF, {PERIOD_W{1'b1}}, 1'b1);
  endtask

  // Ticks that fire the periodic and one-shot channels, then clean up.
  task automatic test_ticks();
    send_request(REQ_TICK, 4'hF, {PERIOD_W{1'b1}}, 1'b1);
    send_request(REQ_TICK, 4'd0, '0, 1'b0);
    send_request(REQ_TICK, 4'd0, '0, 1'b0);
    send_request(REQ_REMOVE, 4'd2, '0, 1'b0);
    send_request(REQ_TICK, 4'd0, '0, 1'b0);
    send_request(REQ_REMOVE, 4'd15, '0, 1'b0);
    send_request(REQ_ADD, 4'd15, {PERIOD_W{1'b1}}, 1'b1);
    send_request(REQ_REMOVE, 4'd15, {PERIOD_W{1'b1}}, 1'b1);
    send_request(REQ_TICK, 4'd0, '0, 1'b0);
  endtask

  // Arm every channel with the same period so that one tick reports all of
  // them, the largest burst a single tick can give.
  task automatic test_all_channels_due();
    for (int ch = 0; ch < NUM_CH; ch++)
      send_request(REQ_REMOVE, ID_W'(ch), PERIOD_W'($urandom()), 1'($urandom()));
    for (int ch = 0; ch < NUM_CH; ch++)
      send_request(REQ_ADD, ID_W'(ch), 31'd2, ch[0]);
    repeat (4) send_request(REQ_TICK, ID_W'($urandom()), '0, 1'b0);
  endtask

  // The sender stops until the block has answered everything, then resumes.
  task automatic test_drain_pause();
    send_request(REQ_ADD, ID_W'($urandom()), 31'd1, 1'b0);
    send_request(REQ_TICK, 4'd0, '0, 1'b0);
    hold_until_drained();
    send_request(REQ_TICK, 4'd0, '0, 1'b0);
  endtask

  // Random mix, leaning on ticks and short periods so channels fire often.
  // Fields that a request ignores still get random values.
  task automatic test_random_traffic(input int count);
    int pick;
    logic [ID_W-1:0] id;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      id = ID_W'($urandom());
      if ($urandom_range(99) < 2) hold_until_drained();
      if (pick < 45)
        send_request(REQ_TICK, id, PERIOD_W'($urandom()), 1'($urandom()));
      else if (pick < 75)
        send_request(REQ_ADD, id, pick_period(), 1'($urandom()));
      else if (pick < 93)
        send_request(REQ_REMOVE, id, PERIOD_W'($urandom()), 1'($urandom()));
      else
        send_request(REQ_UNUSED, id, PERIOD_W'($urandom()), 1'($urandom()));
    end
  endtask

  initial begin
    now_ms = '0;
    foreach (ch_armed[ch]) begin
      ch_armed[ch] = 1'b0;
      ch_base[ch] = '0;
      ch_period[ch] = '0;
      ch_once[ch] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Light sender idling against a heavily stalled receiver.
    tx_idle_pct = 12;
    rx_stall_pct = 65;
    test_add_remove_errors();
    test_ticks();
    test_all_channels_due();
    test_drain_pause();
    test_random_traffic(140);

    // Heavy sender idling against a lightly stalled receiver.
    tx_idle_pct = 65;
    rx_stall_pct = 12;
    test_random_traffic(140);

    // Back to back on both sides.
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    test_random_traffic(140);

    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("Sent %0d requests; checked %0d results, %0d expirations, %0d error statuses.",
             requests_sent, reports_seen, fires_seen, error_reports);
    $display("Largest single tick reported %0d channels; mismatches: %0d.",
             busiest_tick, mismatch_count);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d results still expected.", expected_reports.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== multi_channel_timeout_table.f =====
+incdir+src
src/mctt_pkg.sv
src/mctt_cell.sv
src/mctt_ctrl.sv
src/multi_channel_timeout_table.sv
verif/tb.sv
